// ===== rtl/rxm_pkg.sv =====
// rxm_pkg: shared widths, constants and the divider lane operand type for the
// RGB-to-XYZ matrix unit. No dependencies.
`default_nettype none

package rxm_pkg;

    localparam int CHROMA_W = 18;             // Q2.16 chromaticity
    localparam int DIFF_W   = CHROMA_W + 1;   // difference of two chromaticities
    localparam int COL_W    = CHROMA_W + 2;   // 1 - x - y
    localparam int PROD_W   = CHROMA_W + DIFF_W;
    localparam int SUM_W    = PROD_W + 2;     // sum of three products
    localparam int DEN_W    = SUM_W + CHROMA_W;
    localparam int NUM_W    = SUM_W + COL_W;
    localparam int FRAC_SH  = 16;             // quotient integer bits
    localparam int DV_W     = DEN_W + FRAC_SH;
    localparam int QBITS    = 33;             // 16 integer + 17 fraction bits
    localparam int ENTRY_W  = 32;
    localparam int LANES    = 9;
    localparam int IN_W     = 8 * CHROMA_W;

    localparam int FRONT_LAT = 5;
    localparam int DIV_LAT   = QBITS + 2;
    localparam int LAT       = FRONT_LAT + DIV_LAT;

    localparam logic signed [COL_W-1:0] ONE_Q16 = COL_W'(65536);
    localparam logic [ENTRY_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [ENTRY_W-1:0] SAT_MIN = 32'h8000_0000;

    typedef struct packed {
        logic             inv;
        logic             neg;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } t_div_op;

endpackage

`default_nettype wire

// ===== rtl/rxm_front.sv =====
// rxm_front: five-stage front end; differences, products, sums, the final
// numerator/denominator products and magnitudes. Depends on rxm_pkg.
`default_nettype none

module rxm_front (
    input  wire logic                       i_clk,
    input  wire logic                       i_en,
    input  wire logic [rxm_pkg::IN_W-1:0]   i_data,
    output rxm_pkg::t_div_op                o_op [rxm_pkg::LANES]
);

    localparam int CW = rxm_pkg::CHROMA_W;

    logic signed [CW-1:0] w_px [3];
    logic signed [CW-1:0] w_py [3];
    logic signed [CW-1:0] w_wx, w_wy;

    assign w_px[0] = i_data[0*CW +: CW];
    assign w_py[0] = i_data[1*CW +: CW];
    assign w_px[1] = i_data[2*CW +: CW];
    assign w_py[1] = i_data[3*CW +: CW];
    assign w_px[2] = i_data[4*CW +: CW];
    assign w_py[2] = i_data[5*CW +: CW];
    assign w_wx    = i_data[6*CW +: CW];
    assign w_wy    = i_data[7*CW +: CW];

    // stage A: differences and third column
    logic signed [CW-1:0] r_a_px [3];
    logic signed [CW-1:0] r_a_wx, r_a_wy;
    logic signed [rxm_pkg::DIFF_W-1:0] r_dbg, r_dgr, r_drb, r_dbw, r_dgw, r_drw;
    logic signed [rxm_pkg::COL_W-1:0] r_a_col [3][3];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_wx <= w_wx;
            r_a_wy <= w_wy;
            r_dbg  <= rxm_pkg::DIFF_W'(w_py[2]) - rxm_pkg::DIFF_W'(w_py[1]);
            r_dgr  <= rxm_pkg::DIFF_W'(w_py[1]) - rxm_pkg::DIFF_W'(w_py[0]);
            r_drb  <= rxm_pkg::DIFF_W'(w_py[0]) - rxm_pkg::DIFF_W'(w_py[2]);
            r_dbw  <= rxm_pkg::DIFF_W'(w_py[2]) - rxm_pkg::DIFF_W'(w_wy);
            r_dgw  <= rxm_pkg::DIFF_W'(w_py[1]) - rxm_pkg::DIFF_W'(w_wy);
            r_drw  <= rxm_pkg::DIFF_W'(w_py[0]) - rxm_pkg::DIFF_W'(w_wy);
            for (int k = 0; k < 3; k++) begin
                r_a_px[k]     <= w_px[k];
                r_a_col[k][0] <= rxm_pkg::COL_W'(w_px[k]);
                r_a_col[k][1] <= rxm_pkg::COL_W'(w_py[k]);
                r_a_col[k][2] <= rxm_pkg::ONE_Q16 - rxm_pkg::COL_W'(w_px[k])
                                 - rxm_pkg::COL_W'(w_py[k]);
            end
        end
    end

    // stage B: twelve products
    localparam int PW = rxm_pkg::PROD_W;
    logic signed [PW-1:0] r_pd [3];
    logic signed [PW-1:0] r_pn [3][3];
    logic signed [CW-1:0] r_b_wy;
    logic signed [rxm_pkg::COL_W-1:0] r_b_col [3][3];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pd[0]    <= PW'(r_a_px[0]) * PW'(r_dbg);
            r_pd[1]    <= PW'(r_a_px[2]) * PW'(r_dgr);
            r_pd[2]    <= PW'(r_a_px[1]) * PW'(r_drb);
            r_pn[0][0] <= PW'(r_a_wx) * PW'(r_dbg);
            r_pn[0][1] <= PW'(r_a_px[1]) * PW'(r_dbw);
            r_pn[0][2] <= PW'(r_a_px[2]) * PW'(r_dgw);
            r_pn[1][0] <= PW'(r_a_wx) * PW'(r_drb);
            r_pn[1][1] <= PW'(r_a_px[0]) * PW'(r_dbw);
            r_pn[1][2] <= PW'(r_a_px[2]) * PW'(r_drw);
            r_pn[2][0] <= PW'(r_a_wx) * PW'(r_dgr);
            r_pn[2][1] <= PW'(r_a_px[0]) * PW'(r_dgw);
            r_pn[2][2] <= PW'(r_a_px[1]) * PW'(r_drw);
            r_b_wy     <= r_a_wy;
            r_b_col    <= r_a_col;
        end
    end

    // stage C: determinant and scale numerators
    localparam int SW = rxm_pkg::SUM_W;
    logic signed [SW-1:0] r_d;
    logic signed [SW-1:0] r_ns [3];
    logic signed [CW-1:0] r_c_wy;
    logic signed [rxm_pkg::COL_W-1:0] r_c_col [3][3];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d     <= SW'(r_pd[0]) + SW'(r_pd[1]) + SW'(r_pd[2]);
            r_ns[0] <= SW'(r_pn[0][0]) - SW'(r_pn[0][1]) + SW'(r_pn[0][2]);
            r_ns[1] <= SW'(r_pn[1][0]) + SW'(r_pn[1][1]) - SW'(r_pn[1][2]);
            r_ns[2] <= SW'(r_pn[2][0]) - SW'(r_pn[2][1]) + SW'(r_pn[2][2]);
            r_c_wy  <= r_b_wy;
            r_c_col <= r_b_col;
        end
    end

    // stage D: denominator, entry numerators, degenerate flag
    localparam int DW = rxm_pkg::DEN_W;
    localparam int NW = rxm_pkg::NUM_W;
    logic signed [DW-1:0] r_den;
    logic signed [NW-1:0] r_num [3][3];
    logic                 r_inv;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_den <= DW'(r_d) * DW'(r_c_wy);
            r_inv <= (r_c_wy == '0) || (r_d == '0);
            for (int k = 0; k < 3; k++) begin
                for (int j = 0; j < 3; j++) begin
                    r_num[k][j] <= NW'(r_ns[k]) * NW'(r_c_col[k][j]);
                end
            end
        end
    end

    // stage E: sign and magnitudes for the divider lanes
    logic [DW-1:0] w_den_mag;
    assign w_den_mag = r_den[DW-1] ? DW'(-r_den) : DW'(r_den);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                for (int j = 0; j < 3; j++) begin
                    o_op[k*3+j].inv <= r_inv;
                    o_op[k*3+j].neg <= r_num[k][j][NW-1] ^ r_den[DW-1];
                    o_op[k*3+j].num <= r_num[k][j][NW-1] ? NW'(-r_num[k][j])
                                                         : NW'(r_num[k][j]);
                    o_op[k*3+j].den <= w_den_mag;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/rxm_div.sv =====
// rxm_div: one pipelined restoring divider lane, one quotient bit per stage,
// with rounding, saturation and zeroing of degenerate results. Uses rxm_pkg.
`default_nettype none

module rxm_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_en,
    input  rxm_pkg::t_div_op                   i_op,
    output logic [rxm_pkg::ENTRY_W-1:0]        o_res
);

    localparam int QB = rxm_pkg::QBITS;
    localparam int VW = rxm_pkg::DV_W;

    logic [VW-1:0] r_rem [0:QB-1];
    logic [VW-1:0] r_dv  [0:QB-1];
    logic [QB-1:0] r_q   [0:QB];
    logic          r_inv [0:QB];
    logic          r_neg [0:QB];
    logic          r_sat [0:QB];

    // entry stage: saturate if the integer part needs more than 16 bits
    logic [VW-1:0] w_dv0;
    logic [VW-1:0] w_num0;
    logic          w_sat0;
    assign w_dv0  = {i_op.den, rxm_pkg::FRAC_SH'(0)};
    assign w_num0 = VW'(i_op.num);
    assign w_sat0 = w_num0 >= w_dv0;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= w_sat0 ? '0 : w_num0;
            r_dv[0]  <= w_dv0;
            r_q[0]   <= '0;
            r_inv[0] <= i_op.inv;
            r_neg[0] <= i_op.neg;
            r_sat[0] <= w_sat0;
        end
    end

    for (genvar g = 1; g <= QB; g++) begin : g_step
        logic [VW:0] w_rem2;
        logic        w_ge;
        assign w_rem2 = {r_rem[g-1], 1'b0};
        assign w_ge   = w_rem2 >= {1'b0, r_dv[g-1]};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[g]   <= {r_q[g-1][QB-2:0], w_ge};
                r_inv[g] <= r_inv[g-1];
                r_neg[g] <= r_neg[g-1];
                r_sat[g] <= r_sat[g-1];
            end
        end

        if (g < QB) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[g] <= w_ge ? VW'(w_rem2 - {1'b0, r_dv[g-1]}) : VW'(w_rem2);
                    r_dv[g]  <= r_dv[g-1];
                end
            end
        end
    end

    // round half away (magnitude), then saturate to Q15.16
    logic [QB:0]   w_sum;
    logic [QB-1:0] w_mag;
    logic [rxm_pkg::ENTRY_W-1:0] n_res;
    assign w_sum = {1'b0, r_q[QB]} + (QB+1)'(1);
    assign w_mag = w_sum[QB:1];

    always_comb begin
        if (r_inv[QB]) begin
            n_res = '0;
        end else if (r_sat[QB]) begin
            n_res = r_neg[QB] ? rxm_pkg::SAT_MIN : rxm_pkg::SAT_MAX;
        end else if (r_neg[QB]) begin
            if (w_mag >= QB'(rxm_pkg::SAT_MIN)) begin
                n_res = rxm_pkg::SAT_MIN;
            end else begin
                n_res = rxm_pkg::ENTRY_W'(-w_mag);
            end
        end else if (w_mag > QB'(rxm_pkg::SAT_MAX)) begin
            n_res = rxm_pkg::SAT_MAX;
        end else begin
            n_res = rxm_pkg::ENTRY_W'(w_mag);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_res <= n_res;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/rgb_to_xyz_matrix_unit.sv =====
// rgb_to_xyz_matrix_unit: top level; front end, nine divider lanes and the
// valid chain. Depends on rxm_pkg, rxm_front and rxm_div.
//
// Usage:
//  Slave channel: one transaction carries the eight Q2.16 chromaticities of
//  the red, green and blue primaries and of the white point.
//  Master channel: one transaction per input transaction, carrying the nine
//  Q15.16 matrix entries (row per primary, columns x, y, z) in tdata and the
//  degenerate-input flag in tuser; entries are zero when the flag is set.
//  Pipeline: from slave acceptance to master tvalid, 5 front-end stages and a
//  35-stage divider per entry (entry stage, one quotient bit per bit stage, output register).
//  Throughput: one transaction per cycle while the output register is not stalled.
//  Stall: the whole pipeline, output register included, advances only when
//  the output register is empty or being taken; while master tready is low
//  and a result waits, slave tready is low and nothing is lost or repeated.
//  Reset: i_rst_n (synchronous, active low) clears the valid chain only.
`default_nettype none

module rgb_to_xyz_matrix_unit (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    // red_x, red_y, green_x, green_y, blue_x, blue_y, white_x, white_y
    input  wire logic [143:0] i_s_axis_tdata,
    output logic              o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    // red_to_x, red_to_y, red_to_z, green_to_x, green_to_y, green_to_z,
    // blue_to_x, blue_to_y, blue_to_z
    output logic [287:0]      o_m_axis_tdata,
    // invalid
    output logic [0:0]        o_m_axis_tuser
);

    localparam int LAT = rxm_pkg::LAT;

    logic               w_en;
    logic [LAT-1:0]     r_vld;
    rxm_pkg::t_div_op   w_op [rxm_pkg::LANES];
    logic [rxm_pkg::ENTRY_W-1:0] w_res [rxm_pkg::LANES];
    logic               r_inv [rxm_pkg::DIV_LAT];

    // pipeline moves when the output register is free or being drained
    assign w_en            = !r_vld[LAT-1] || i_m_axis_tready;
    assign o_s_axis_tready = w_en;
    assign o_m_axis_tvalid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_s_axis_tvalid};
        end
    end

    rxm_front u_front (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_data (i_s_axis_tdata),
        .o_op   (w_op)
    );

    for (genvar g = 0; g < rxm_pkg::LANES; g++) begin : g_lane
        rxm_div u_div (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_op  (w_op[g]),
            .o_res (w_res[g])
        );
        assign o_m_axis_tdata[g*rxm_pkg::ENTRY_W +: rxm_pkg::ENTRY_W] = w_res[g];
    end

    // degenerate flag follows the divider lanes
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_inv[0] <= w_op[0].inv;
            for (int i = 1; i < rxm_pkg::DIV_LAT; i++) begin
                r_inv[i] <= r_inv[i-1];
            end
        end
    end

    assign o_m_axis_tuser[0] = r_inv[rxm_pkg::DIV_LAT-1];

`ifndef NO_ASSERTIONS
    a_inv_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[0] |-> o_m_axis_tdata == '0)
        else $error("degenerate result with non-zero entries");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid straight after reset");

    a_stall_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |=> $stable(r_vld))
        else $error("valid chain moved during stall");
`endif

endmodule

`default_nettype wire

// ===== bench/rgb_to_xyz_matrix_unit_check.sv =====
// rgb_to_xyz_matrix_unit_check: watches both stream channels of the matrix unit,
// predicts each matrix from the accepted chromaticities and compares in order.
// Depends on nothing but the port widths of rgb_to_xyz_matrix_unit.
`default_nettype none

module rgb_to_xyz_matrix_unit_check (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_axis_tvalid,
    input  wire logic         i_s_axis_tready,
    input  wire logic [143:0] i_s_axis_tdata,
    input  wire logic         i_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    input  wire logic [287:0] i_m_axis_tdata,
    input  wire logic [0:0]   i_m_axis_tuser,
    output int                o_errors,
    output int                o_pending
);

    typedef struct packed {
        logic         invalid;
        logic [287:0] entries;
    } t_matrix;

    t_matrix matrices_due[$];

    initial o_errors = 0;
    initial o_pending = 0;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h, expected %h at %0t", what, got, want, $time);
        o_errors++;
    endtask

    // round(num * 2^16 / den), ties away from zero, saturated to 32 bits
    function automatic logic [31:0] quot_q16(input longint num, input longint den);
        logic            neg;
        longint unsigned n, dd, q, r, mag;
        neg = (num < 0) != (den < 0);
        n   = (num < 0) ? -num : num;
        dd  = (den < 0) ? -den : den;
        q   = n / dd;
        r   = n % dd;
        if (q >= 64'h10000) begin
            mag = 64'h1_0000_0000;
        end else begin
            for (int i = 0; i < 17; i++) begin
                r = r << 1;
                q = q << 1;
                if (r >= dd) begin
                    r = r - dd;
                    q = q | 1;
                end
            end
            mag = (q + 1) >> 1;
        end
        if (neg)
            return (mag >= 64'h8000_0000) ? 32'h8000_0000 : 32'(-longint'(mag));
        return (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : 32'(mag);
    endfunction

    function automatic t_matrix predict_matrix(input logic [143:0] chroma);
        longint  c [8];
        longint  px [3], py [3], scale_num [3], col [3];
        longint  det, den;
        t_matrix m;
        for (int i = 0; i < 8; i++)
            c[i] = longint'(signed'(chroma[i*18 +: 18]));
        px = '{c[0], c[2], c[4]};
        py = '{c[1], c[3], c[5]};
        det = c[0] * (c[5] - c[3]) + c[4] * (c[3] - c[1]) + c[2] * (c[1] - c[5]);
        m = '0;
        if (c[7] == 0 || det == 0) begin
            m.invalid = 1'b1;
            return m;
        end
        den = det * c[7];
        scale_num[0] = c[6] * (c[5] - c[3]) - c[2] * (c[5] - c[7]) + c[4] * (c[3] - c[7]);
        scale_num[1] = c[6] * (c[1] - c[5]) + c[0] * (c[5] - c[7]) - c[4] * (c[1] - c[7]);
        scale_num[2] = c[6] * (c[3] - c[1]) - c[0] * (c[3] - c[7]) + c[2] * (c[1] - c[7]);
        for (int k = 0; k < 3; k++) begin
            col = '{px[k], py[k], 65536 - px[k] - py[k]};
            for (int j = 0; j < 3; j++)
                m.entries[(k*3+j)*32 +: 32] = quot_q16(scale_num[k] * col[j], den);
        end
        return m;
    endfunction

    always @(posedge i_clk) begin
        t_matrix want;
        if (i_rst_n) begin
            if (i_s_axis_tvalid && i_s_axis_tready)
                matrices_due.push_back(predict_matrix(i_s_axis_tdata));
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                if (matrices_due.size() == 0) begin
                    $display("unexpected result transaction at %0t", $time);
                    o_errors++;
                end else begin
                    want = matrices_due.pop_front();
                    for (int e = 0; e < 9; e++)
                        if (i_m_axis_tdata[e*32 +: 32] !== want.entries[e*32 +: 32])
                            report_mismatch($sformatf("entry %0d", e),
                                            i_m_axis_tdata[e*32 +: 32],
                                            want.entries[e*32 +: 32]);
                    if (i_m_axis_tuser[0] !== want.invalid)
                        report_mismatch("invalid", 32'(i_m_axis_tuser[0]),
                                        32'(want.invalid));
                end
            end
        end
        o_pending = matrices_due.size();
    end

endmodule

`default_nettype wire

// ===== bench/rgb_to_xyz_matrix_unit_test.sv =====
// rgb_to_xyz_matrix_unit_test: stimulus and verdict for the matrix unit; the
// checker module does all prediction. Depends on rgb_to_xyz_matrix_unit and
// rgb_to_xyz_matrix_unit_check.
`default_nettype none

module rgb_to_xyz_matrix_unit_test;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    // red_x, red_y, green_x, green_y, blue_x, blue_y, white_x, white_y
    logic [143:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    // nine entries, row by row, from red_to_x up
    logic [287:0] m_tdata;
    // invalid
    logic [0:0]   m_tuser;
    int           errors, pending;

    // idle rates in percent, changed per phase
    int send_idle = 0;
    int recv_idle = 0;

    always #5 i_clk = ~i_clk;

    rgb_to_xyz_matrix_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    rgb_to_xyz_matrix_unit_check checker_inst (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .i_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .i_m_axis_tdata  (m_tdata),
        .i_m_axis_tuser  (m_tuser),
        .o_errors        (errors),
        .o_pending       (pending)
    );

    // receiver stalls at random, redrawn every falling edge
    always @(negedge i_clk)
        m_tready <= ($urandom_range(99) >= recv_idle);

    // one input transaction; valid is only touched once per falling edge
    task automatic send_chroma(input int rx, ry, gx, gy, bx, by, wx, wy);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {18'(wy), 18'(wx), 18'(by), 18'(bx),
                     18'(gy), 18'(gx), 18'(ry), 18'(rx)};
        do @(posedge i_clk); while (!(s_tvalid && s_tready));
        @(negedge i_clk);
    endtask

    // realistic chromaticity: mostly within 0..1, sometimes anywhere
    function automatic logic [17:0] pick_chroma(input int wild);
        if ($urandom_range(99) < wild)
            return 18'($urandom);
        return 18'($urandom_range(65536));
    endfunction

    task automatic send_random(input int wild);
        logic [17:0] c [8];
        int          kind;
        foreach (c[i]) c[i] = pick_chroma(wild);
        kind = $urandom_range(99);
        if (kind < 4) begin
            c[7] = '0;                          // white y zero
        end else if (kind < 8) begin
            c[2] = c[0];                        // two primaries coincide: no area
            c[3] = c[1];
        end else if (kind < 11) begin
            // tiny triangle around the red primary: huge scale factors
            c[2] = c[0] + 18'($urandom_range(3));
            c[3] = c[1];
            c[4] = c[0];
            c[5] = c[1] + 18'($urandom_range(1, 3));
        end
        send_chroma(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7]);
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: sRGB with D65, degenerate cases, saturation, extremes
        send_chroma(41943, 21627, 19661, 39322, 9830, 3932, 20493, 21561);
        send_chroma(0, 0, 0, 0, 0, 0, 0, 0);
        send_chroma(41943, 21627, 19661, 39322, 9830, 3932, 20493, 0);
        send_chroma(41943, 21627, 41943, 21627, 9830, 3932, 20493, 21561);
        send_chroma(0, 0, 32768, 32768, 65536, 65536, 20000, 20000);
        send_chroma(1, 0, 0, 1, 0, 0, 131071, 1);
        send_chroma(1, 0, 0, 1, 0, 0, -131072, 1);
        send_chroma(-131072, -131072, 131071, -131072, -131072, 131071,
                    131071, 131071);
        send_chroma(131071, 131071, -131072, 131071, 131071, -131072,
                    -131072, -131072);
        send_chroma(-131072, 131071, 131071, -131072, 0, 0, -131072, 131071);
        send_chroma(65536, 0, 0, 65536, 0, 0, 21845, 21845);
        send_chroma(-1, -1, 1, -1, -1, 1, -1, -1);
        send_chroma(47841, 20963, 17433, 45613, 8598, 3893, 20605, 21627);
        s_tvalid <= 1'b0;

        // hold the sender off until the pipeline has drained completely
        wait (pending == 0);
        @(negedge i_clk);

        send_idle = 26;
        recv_idle = 87;
        repeat (560) send_random(15);
        send_idle = 87;
        recv_idle = 26;
        repeat (560) send_random(15);
        send_idle = 0;
        recv_idle = 0;
        repeat (560) send_random(15);
        s_tvalid <= 1'b0;

        wait (pending == 0);
        repeat (60) @(posedge i_clk);
        if (errors == 0 && pending == 0)
            $display("rgb_to_xyz_matrix_unit_test: PASS");
        else
            $display("rgb_to_xyz_matrix_unit_test: FAIL");
        $finish;
    end

    // guard against a hung handshake
    initial begin
        #30000000;
        $display("rgb_to_xyz_matrix_unit_test: FAIL");
        $finish;
    end

endmodule

`default_nettype wire

// ===== rgb_to_xyz_matrix_unit.f =====
rtl/rxm_pkg.sv
rtl/rxm_front.sv
rtl/rxm_div.sv
rtl/rgb_to_xyz_matrix_unit.sv
bench/rgb_to_xyz_matrix_unit_check.sv
bench/rgb_to_xyz_matrix_unit_test.sv
